// ----- src/spr_pkg.sv -----
// shared types, codes and constants of the servo ramp planner
`timescale 1ns / 1ps

package spr_pkg;

	localparam int CH_IN_W   = 4;
	localparam int AIM_W     = 12;
	localparam int TIME_IN_W = 16;
	localparam int TIME_W    = 14;

	localparam logic [AIM_W-1:0]  SET_MAX  = 12'd2490;
	localparam logic [AIM_W-1:0]  SET_MIN  = 12'd510;
	localparam logic [AIM_W-1:0]  SNAP_MIN = 12'd500;
	localparam logic [TIME_W-1:0] TIME_MAX = 14'd10000;
	localparam logic [TIME_W-1:0] TICK_MS  = 14'd20;

	// command codes
	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_STOP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_IGN  = 2'd3;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]         op;
		logic               short_mv;
		logic [CH_IN_W-1:0] channel;
		logic [AIM_W-1:0]   aim;
		logic [TIME_W-1:0]  move_ms;
	} cmd_t;

	// power-on pulse width of each channel
	function automatic logic [AIM_W-1:0] start_pos(input int ch);
		logic [AIM_W-1:0] p;
		case (ch)
			0: p = 12'd837;
			1: p = 12'd1300;
			2: p = 12'd1064;
			3: p = 12'd2218;
			4: p = 12'd1500;
			5: p = 12'd1000;
			default: p = 12'd1350;
		endcase
		return p;
	endfunction

endpackage

// ----- src/spr_front.sv -----
// front end: takes input words, clamps and classifies them into commands
`timescale 1ns / 1ps

module spr_front
	import spr_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        q_full,
	output logic        push,
	output cmd_t        cmd
);

	logic [CH_IN_W-1:0]   channel;
	logic [AIM_W-1:0]     aim;
	logic [TIME_IN_W-1:0] move_time;
	logic                 ign;
	logic [TIME_W-1:0]    time_c;

	assign channel   = s_tdata[3:0];
	assign aim       = s_tdata[15:4];
	assign move_time = s_tdata[31:16];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	assign ign    = {1'b0, channel} >= 5'(CHANNELS);
	assign time_c = (move_time > {2'b00, TIME_MAX}) ? TIME_MAX : move_time[TIME_W-1:0];

	always_comb begin
		cmd.channel  = channel;
		cmd.move_ms  = time_c;
		cmd.short_mv = time_c < TICK_MS;
		if (aim > SET_MAX) begin
			cmd.aim = SET_MAX;
		end else if (aim < SET_MIN) begin
			cmd.aim = SET_MIN;
		end else begin
			cmd.aim = aim;
		end
		if (ign) begin
			cmd.op = OP_IGN;
		end else if (s_tuser) begin
			cmd.op = OP_TICK;
		end else if (aim == '0) begin
			cmd.op = OP_STOP;
		end else begin
			cmd.op = OP_SET;
		end
	end

endmodule

// ----- src/spr_queue.sv -----
// short command queue between front and back end
`timescale 1ns / 1ps

module spr_queue
	import spr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rd_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign valid   = cnt_q != '0;
	assign rd_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/spr_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module spr_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_nx;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	assign done   = done_q;
	assign quot   = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- src/spr_back.sv -----
// back end: channel state, ramp arithmetic and output register
`timescale 1ns / 1ps

module spr_back
	import spr_pkg::*;
#(
	parameter int CHANNELS  = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_data,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int POS_W  = AIM_W + FRAC_BITS;
	localparam int STEP_W = POS_W + 1;
	localparam int NUM_W  = POS_W + 5;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [POS_W-1:0] TINY_FIX =
		POS_W'(((64'd77 << FRAC_BITS) + 64'd5000) / 64'd10000);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_WB   = 2'd3;

	// per-channel state
	logic [POS_W-1:0]         cur_q [CHANNELS];
	logic [POS_W-1:0]         tgt_q [CHANNELS];
	logic signed [STEP_W-1:0] stp_q [CHANNELS];

	logic [1:0]               st_q;
	cmd_t                     cmd_q;
	logic [CH_W-1:0]          idx_q;
	logic [POS_W-1:0]         rd_cur_q;
	logic [POS_W-1:0]         rd_tgt_q;
	logic signed [STEP_W-1:0] rd_stp_q;

	logic                     out_valid_q;
	logic [CH_IN_W-1:0]       out_chan_q;
	logic [AIM_W-1:0]         out_pos_q;
	logic                     out_moving_q;
	logic                     out_ign_q;

	logic                     out_free;
	logic                     need_div;
	logic                     fire;
	logic [CH_W-1:0]          rd_idx;

	logic [POS_W-1:0]         aim_fix;
	logic [POS_W-1:0]         aim_adj;
	logic signed [STEP_W-1:0] diff;
	logic signed [STEP_W-1:0] diff_neg;
	logic [POS_W-1:0]         diff_mag;
	logic [NUM_W-1:0]         numer;

	logic                     div_done;
	logic [NUM_W-1:0]         div_quot;
	logic signed [STEP_W-1:0] q_pos;
	logic signed [STEP_W-1:0] q_neg;

	logic [AIM_W-1:0]         snap_int;
	logic [AIM_W-1:0]         snap_c;
	logic [POS_W-1:0]         snap_fix;
	logic signed [STEP_W-1:0] gap;
	logic signed [STEP_W-1:0] gap_neg;
	logic [POS_W-1:0]         gap_mag;
	logic signed [STEP_W-1:0] stp_neg;
	logic [POS_W-1:0]         stp_mag;
	logic                     close;
	logic signed [STEP_W-1:0] sum;

	logic [POS_W-1:0]         nxt_cur;
	logic [POS_W-1:0]         nxt_tgt;
	logic signed [STEP_W-1:0] nxt_stp;

	assign out_free = !out_valid_q || m_tready;
	assign need_div = (cmd_q.op == OP_SET) && !cmd_q.short_mv;
	assign fire     = out_free && (((st_q == S_EXEC) && !need_div) || (st_q == S_WB));
	assign pop      = (st_q == S_IDLE) && q_valid;
	assign rd_idx   = (q_data.op == OP_IGN) ? '0 : q_data.channel[CH_W-1:0];

	// set: target in fixed point, nudged when it equals the position
	assign aim_fix  = {cmd_q.aim, {FRAC_BITS{1'b0}}};
	assign aim_adj  = (rd_cur_q == aim_fix) ? aim_fix + TINY_FIX : aim_fix;
	assign diff     = $signed({1'b0, aim_adj}) - $signed({1'b0, rd_cur_q});
	assign diff_neg = -diff;
	assign diff_mag = diff[STEP_W-1] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];
	// |diff| * 20 as two shifted adds
	assign numer    = ({5'b0, diff_mag} << 4) + ({5'b0, diff_mag} << 2);
	assign q_pos    = $signed({1'b0, div_quot[POS_W-1:0]});
	assign q_neg    = -q_pos;

	// tick: snap point and distance check
	assign snap_int = rd_tgt_q[POS_W-1:FRAC_BITS];
	assign snap_c   = (snap_int > SET_MAX) ? SET_MAX :
	                  (snap_int < SNAP_MIN) ? SNAP_MIN : snap_int;
	assign snap_fix = {snap_c, {FRAC_BITS{1'b0}}};
	assign gap      = $signed({1'b0, snap_fix}) - $signed({1'b0, rd_cur_q});
	assign gap_neg  = -gap;
	assign gap_mag  = gap[STEP_W-1] ? gap_neg[POS_W-1:0] : gap[POS_W-1:0];
	assign stp_neg  = -rd_stp_q;
	assign stp_mag  = rd_stp_q[STEP_W-1] ? stp_neg[POS_W-1:0] : rd_stp_q[POS_W-1:0];
	assign close    = {1'b0, gap_mag} <= {stp_mag, 1'b0};
	assign sum      = $signed({1'b0, rd_cur_q}) + rd_stp_q;

	always_comb begin
		nxt_cur = rd_cur_q;
		nxt_tgt = rd_tgt_q;
		nxt_stp = rd_stp_q;
		case (cmd_q.op)
			OP_STOP: begin
				nxt_tgt = rd_cur_q;
				nxt_stp = '0;
			end
			OP_SET: begin
				nxt_tgt = aim_adj;
				if (cmd_q.short_mv) begin
					nxt_cur = aim_adj;
					nxt_stp = '0;
				end else begin
					nxt_stp = diff[STEP_W-1] ? q_neg : q_pos;
				end
			end
			OP_TICK: begin
				if (rd_stp_q != '0) begin
					if (close) begin
						nxt_cur = snap_fix;
						nxt_stp = '0;
					end else begin
						nxt_cur = sum[POS_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	spr_div #(
		.NUM_W (NUM_W),
		.DEN_W (TIME_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((st_q == S_EXEC) && need_div),
		.numer  (numer),
		.denom  (cmd_q.move_ms),
		.done   (div_done),
		.quot   (div_quot)
	);

	// command snapshot, loaded when a command leaves the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q    <= q_data;
			idx_q    <= rd_idx;
			rd_cur_q <= cur_q[rd_idx];
			rd_tgt_q <= tgt_q[rd_idx];
			rd_stp_q <= stp_q[rd_idx];
		end
		if (fire) begin
			out_chan_q   <= cmd_q.channel;
			out_ign_q    <= cmd_q.op == OP_IGN;
			out_pos_q    <= (cmd_q.op == OP_IGN) ? '0 : nxt_cur[POS_W-1:FRAC_BITS];
			out_moving_q <= (cmd_q.op != OP_IGN) && (nxt_stp != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cur_q[i] <= {start_pos(i), {FRAC_BITS{1'b0}}};
				tgt_q[i] <= {start_pos(i), {FRAC_BITS{1'b0}}};
				stp_q[i] <= '0;
			end
		end else if (fire && (cmd_q.op != OP_IGN)) begin
			cur_q[idx_q] <= nxt_cur;
			tgt_q[idx_q] <= nxt_tgt;
			stp_q[idx_q] <= nxt_stp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (need_div) begin
						st_q <= S_DIV;
					end else if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						st_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pos_q, out_chan_q};
	assign m_tuser  = {out_ign_q, out_moving_q};

endmodule

// ----- src/servo_pulse_ramp_planner_top.sv -----
// top level of the multi-channel servo ramp planner
`timescale 1ns / 1ps

// flow: a tick, stop, short move or ignored channel goes from the queue through the back end's
//   idle and exec states into the result register; a timed move also runs the divider between
//   exec and write-back; the back end takes a new word only when done with the last, bound by
//   the one-bit-per-cycle divider; a two-entry queue lets input words arrive while it is busy
// reset (arst_n low, asynchronous): queue and output emptied, every channel back at its start
//   position with zero step

module servo_pulse_ramp_planner_top
	import spr_pkg::*;
#(
	parameter int CHANNELS  = 8,   // number of servo channels, 1..16
	parameter int FRAC_BITS = 16   // fraction bits of positions and steps, 8..24
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // channel[3:0], target_pulse[15:4], move_time[31:16]
	input  logic        s_tuser,   // func: 0 set target (stop when target_pulse is 0), 1 tick
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // channel_out[3:0], position[15:4]
	output logic [1:0]  m_tuser    // moving[0], ignored[1]
);

	// front to queue
	logic q_push;
	logic q_full;
	cmd_t q_wr;

	// queue to back end
	logic q_pop;
	logic q_valid;
	cmd_t q_rd;

	// decode and clamp of the incoming word
	spr_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_wr)
	);

	// decouples the front from the divider-bound back end
	spr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_data (q_rd)
	);

	// channel state, step computation and result register
	spr_back #(
		.CHANNELS  (CHANNELS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_rd),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
